// ===== src/dsfa_pkg.sv =====
// Shared types, constants and a helper function for the dual sample FIFO audio channel.
`timescale 1ns / 1ps
package dsfa_pkg;

    localparam int FIFO_DEPTH   = 32;
    localparam int REFILL_LEVEL = 17;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = PTR_W + 1;
    localparam int MAX_BYTES    = 4;
    localparam int CFG_AW       = 4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TIMER = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TSEL_A = 2'd0,
        REG_TSEL_B = 2'd1,
        REG_VOL_A  = 2'd2,
        REG_VOL_B  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic tsel_a;
        logic tsel_b;
        logic vol_a;
        logic vol_b;
    } t_cfg;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clr;
        logic [2:0] nbytes;
    } t_chan_ctrl;

    // Sign-extends a held sample and multiplies it by two or four.
    function automatic logic signed [9:0] scale_sample(input logic [7:0] held,
                                                       input logic vol);
        logic signed [9:0] res;
        if (vol) begin
            res = {held, 2'b00};
        end else begin
            res = {held[7], held, 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== src/dsfa_cfg.sv =====
// APB-style configuration registers: timer selects and volume bits.
`timescale 1ns / 1ps
module dsfa_cfg
    import dsfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (t_reg_idx'(paddr[CFG_AW-1:2]))
                REG_TSEL_A: n_cfg.tsel_a = pwdata[0];
                REG_TSEL_B: n_cfg.tsel_b = pwdata[0];
                REG_VOL_A:  n_cfg.vol_a  = pwdata[0];
                REG_VOL_B:  n_cfg.vol_b  = pwdata[0];
                default:    n_cfg        = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[CFG_AW-1:2]))
            REG_TSEL_A: prdata = {31'd0, r_cfg.tsel_a};
            REG_TSEL_B: prdata = {31'd0, r_cfg.tsel_b};
            REG_VOL_A:  prdata = {31'd0, r_cfg.vol_a};
            REG_VOL_B:  prdata = {31'd0, r_cfg.vol_b};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/dsfa_chan.sv =====
// One sample FIFO channel with read pointer, fill count and held sample register.
`timescale 1ns / 1ps
module dsfa_chan
    import dsfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chan_ctrl i_ctrl,
    input  logic [31:0] i_data,
    output logic [7:0] o_held,
    output logic       o_repl
);

    logic [7:0]       r_store [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_held;
    logic             r_repl;
    logic             n_repl;
    logic [CNT_W-1:0] space;
    logic [CNT_W-1:0] take;
    logic [CNT_W-1:0] nb_ext;

    // Bytes beyond the free space are dropped.
    assign space  = CNT_W'(FIFO_DEPTH) - r_count;
    assign nb_ext = CNT_W'(i_ctrl.nbytes);
    assign take   = (nb_ext < space) ? nb_ext : space;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_repl  = 1'b0;
        if (i_ctrl.clr) begin
            n_head  = '0;
            n_count = '0;
        end else if (i_ctrl.pop) begin
            if (r_count != '0) begin
                n_head  = r_head + PTR_W'(1);
                n_count = r_count - CNT_W'(1);
            end
            n_repl = (n_count < CNT_W'(REFILL_LEVEL));
        end else if (i_ctrl.push) begin
            n_count = r_count + take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.clr && !i_ctrl.pop) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
                if (CNT_W'(k) < take) begin
                    r_store[r_head + r_count[PTR_W-1:0] + PTR_W'(k)] <= i_data[8*k +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_held  <= '0;
            r_repl  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_repl  <= n_repl;
            // A pop from an empty FIFO keeps the held sample.
            if (i_ctrl.clr) begin
                r_held <= '0;
            end else if (i_ctrl.pop && (r_count != '0)) begin
                r_held <= r_store[r_head];
            end
        end
    end

    assign o_held = r_held;
    assign o_repl = r_repl;

endmodule

// ===== src/dual_sample_fifo_audio_channel_top.sv =====
// Top level of the dual sample FIFO audio channel: command decode, channels, result strobe.
// An accepted request passes the decode register, then the channel update raises its result strobe (o_valid).
// Throughput: one request per cycle while busy is low, set by the single decode register and channel update.
// busy is high only during reset and the cycle after it; otherwise every start is taken.
// Reset (synchronous, active low) empties both FIFOs, zeroes held samples and config.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module dual_sample_fifo_audio_channel_top
    import dsfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [3:0]        i_addr_offset,
    input  logic [31:0]       i_write_data,
    input  logic [2:0]        i_byte_count,
    input  logic [1:0]        i_timer_index,
    input  logic              i_clear_a,
    input  logic              i_clear_b,
    output logic              o_valid,
    output logic signed [9:0] o_sample_a,
    output logic signed [9:0] o_sample_b,
    output logic              o_replenish_a,
    output logic              o_replenish_b,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       cfg;
    logic       r_busy;
    logic       accept;
    logic [2:0] nbytes;
    t_chan_ctrl n_ctrl_a;
    t_chan_ctrl n_ctrl_b;
    t_chan_ctrl r_ctrl_a;
    t_chan_ctrl r_ctrl_b;
    logic [31:0] r_data;
    logic       r_valid;
    logic       r_out_valid;
    logic [7:0] held_a;
    logic [7:0] held_b;

    // Configuration registers; software only writes them while no request is in flight (the block does not enforce it).
    dsfa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Access sizes above four bytes behave as a full word; size zero pushes nothing.
    assign nbytes = (i_byte_count > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : i_byte_count;

    // Decode the request into one control word per channel. An unused command code
    // and an offset outside both FIFO windows leave both channels untouched.
    always_comb begin
        n_ctrl_a        = '0;
        n_ctrl_b        = '0;
        n_ctrl_a.nbytes = nbytes;
        n_ctrl_b.nbytes = nbytes;
        if (accept) begin
            case (t_cmd'(i_cmd))
                CMD_WRITE: begin
                    n_ctrl_a.push = (i_addr_offset[3:2] == 2'b00);
                    n_ctrl_b.push = (i_addr_offset[3:2] == 2'b01);
                end
                CMD_TIMER: begin
                    // Timers two and three can never match a one-bit select.
                    n_ctrl_a.pop = (i_timer_index == {1'b0, cfg.tsel_a});
                    n_ctrl_b.pop = (i_timer_index == {1'b0, cfg.tsel_b});
                end
                CMD_CLEAR: begin
                    n_ctrl_a.clr = i_clear_a;
                    n_ctrl_b.clr = i_clear_b;
                end
                default: begin
                    n_ctrl_a.push = 1'b0;
                    n_ctrl_b.push = 1'b0;
                end
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl_a    <= '0;
            r_ctrl_b    <= '0;
        end else begin
            r_busy      <= 1'b0;
            r_valid     <= accept;
            r_out_valid <= r_valid;
            r_ctrl_a    <= n_ctrl_a;
            r_ctrl_b    <= n_ctrl_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= i_write_data;
    end

    // Each channel updates its FIFO state and held sample at the same edge that
    // raises the result strobe, so the result reflects the state after the request.
    dsfa_chan u_chan_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl_a),
        .i_data  (r_data),
        .o_held  (held_a),
        .o_repl  (o_replenish_a)
    );

    dsfa_chan u_chan_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl_b),
        .i_data  (r_data),
        .o_held  (held_b),
        .o_repl  (o_replenish_b)
    );

    assign o_valid    = r_out_valid;
    assign o_sample_a = scale_sample(held_a, cfg.vol_a);
    assign o_sample_b = scale_sample(held_b, cfg.vol_b);

`ifndef SYNTH
    // Every accepted request produces its result strobe after the decode register and the result register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_valid)
        else $error("accepted request produced no result strobe");

    // Replenish flags only appear alongside a result strobe.
    a_repl_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_replenish_a || o_replenish_b) |-> o_valid)
        else $error("replenish raised without a result");

    // Clearing channel A forces its reported sample to zero.
    a_clear_a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_CLEAR && i_clear_a |=> ##1 (o_sample_a == 10'sd0))
        else $error("channel A sample not zero after clear");

    // Clearing channel B forces its reported sample to zero.
    a_clear_b_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_CLEAR && i_clear_b |=> ##1 (o_sample_b == 10'sd0))
        else $error("channel B sample not zero after clear");
`endif

endmodule
